// File: hdl/wpm_pkg.sv
// Package for the wildcard pattern matcher: opcodes, pattern byte classes
// and the packed input and result beat types. No dependencies.
`timescale 1ns / 1ps

package wpm_pkg;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_EVAL    = 2'd2,
        OP_NONE    = 2'd3
    } wpm_op_t;

    localparam logic [7:0] CH_LOW  = 8'h61;
    localparam logic [7:0] CH_HIGH = 8'h7A;
    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
    } wpm_in_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } wpm_out_t;

endpackage

// File: hdl/wpm_row_step.sv
// One pattern byte step of the match row update, applied to all text lanes.
// Depends on wpm_pkg for the pattern byte classes.
`timescale 1ns / 1ps

module wpm_row_step #(
    parameter int MAX_TEXT = 64
) (
    input  logic [MAX_TEXT:0]        row,
    input  logic [7:0]               pat_byte,
    input  logic [MAX_TEXT-1:0][7:0] text,
    input  logic [MAX_TEXT-1:0]      lane_mask,
    output logic [MAX_TEXT:0]        row_next
);
    import wpm_pkg::*;

    localparam int RW    = MAX_TEXT + 1;
    localparam int STEPS = (RW > 1) ? $clog2(RW) : 1;

    logic            is_literal;
    logic            is_any;
    logic [RW-1:0]   hit;
    logic [RW-1:0]   suffix_or;

    always_comb
    begin
        is_literal = pat_byte inside {[CH_LOW:CH_HIGH]};
        is_any     = (pat_byte == CH_ANY);
    end

    always_comb
    begin
        hit = '0;
        for (int k = 0; k < MAX_TEXT; k++)
        begin
            hit[k] = lane_mask[k] & (!is_literal || (text[k] == pat_byte));
        end
    end

    // A star matches any run, so a lane becomes true if any later lane is.
    always_comb
    begin
        suffix_or = row;
        for (int s = 0; s < STEPS; s++)
        begin
            suffix_or = suffix_or | (suffix_or >> (1 << s));
        end
    end

    always_comb
    begin
        if (is_literal || is_any)
        begin
            row_next = (row >> 1) & hit;
        end
        else
        begin
            row_next = suffix_or;
        end
    end

endmodule

// File: hdl/wildcard_pattern_matcher.sv
// Wildcard pattern matcher top level: pattern and text stores, evaluation
// sequencer and result register. Depends on wpm_pkg and wpm_row_step.
// Flow: an accepted load beat is written to its store; an evaluate beat runs
// S_RUN over the pattern and S_DONE registers its result; overflow skips S_RUN.
// Throughput: one load per cycle; the row unit takes one pattern byte per
// cycle, and input is held off while an evaluation runs or its result waits.
// Reset clears counts, overflow flag, sequencer and result valid; stores keep data.
`timescale 1ns / 1ps

module wildcard_pattern_matcher #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_TEXT    = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  wpm_pkg::wpm_in_t in_beat,
    output logic             out_valid,
    input  logic             out_ready,
    output wpm_pkg::wpm_out_t out_beat
);
    import wpm_pkg::*;

    localparam int PCW = $clog2(MAX_PATTERN + 1);
    localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int TCW = $clog2(MAX_TEXT + 1);
    localparam int TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int RW  = MAX_TEXT + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    logic [7:0]                pattern_mem [MAX_PATTERN];
    logic [MAX_TEXT-1:0][7:0]  text_reg;
    logic [7:0]                pat_rd_reg;
    logic [PAW-1:0]            rd_addr;
    logic [PCW-1:0]            rd_calc;

    state_t                    state_reg, state_next;
    logic [PCW-1:0]            pcount_reg;
    logic [TCW-1:0]            tcount_reg;
    logic                      ovf_seen_reg;
    logic [PCW-1:0]            idx_reg;
    logic [RW-1:0]             row_reg;
    logic [RW-1:0]             row_next;
    logic [MAX_TEXT-1:0]       lane_mask_reg;
    logic [MAX_TEXT-1:0]       lane_mask_init;
    logic                      ovf_res_reg;
    logic                      out_valid_reg;
    wpm_out_t                  out_beat_reg;

    logic                      in_fire;
    logic                      op_pat;
    logic                      op_txt;
    logic                      op_eval;
    logic                      pat_full;
    logic                      txt_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign op_pat    = in_fire && (in_beat.opcode == OP_PATTERN);
    assign op_txt    = in_fire && (in_beat.opcode == OP_TEXT);
    assign op_eval   = in_fire && (in_beat.opcode == OP_EVAL);
    assign pat_full  = (pcount_reg >= PCW'(MAX_PATTERN));
    assign txt_full  = (tcount_reg >= TCW'(MAX_TEXT));
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    always_comb
    begin
        lane_mask_init = '0;
        for (int k = 0; k < MAX_TEXT; k++)
        begin
            lane_mask_init[k] = (TCW'(k) < tcount_reg);
        end
    end

    // The read for the next pattern byte is issued in the cycle before its use, via pat_rd_reg.
    always_comb
    begin
        if (state_reg == S_RUN)
        begin
            rd_calc = idx_reg - PCW'(2);
        end
        else
        begin
            rd_calc = pcount_reg - PCW'(1);
        end
        rd_addr = rd_calc[PAW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (op_pat && !pat_full)
        begin
            pattern_mem[pcount_reg[PAW-1:0]] <= in_beat.symbol;
        end
        pat_rd_reg <= pattern_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (op_txt && !txt_full)
        begin
            text_reg[tcount_reg[TAW-1:0]] <= in_beat.symbol;
        end
    end

    wpm_row_step #(
        .MAX_TEXT (MAX_TEXT)
    ) u_row_step (
        .row       (row_reg),
        .pat_byte  (pat_rd_reg),
        .text      (text_reg),
        .lane_mask (lane_mask_reg),
        .row_next  (row_next)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op_eval)
                begin
                    state_next = ovf_seen_reg ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pcount_reg    <= '0;
            tcount_reg    <= '0;
            ovf_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (op_pat)
            begin
                if (pat_full)
                begin
                    ovf_seen_reg <= 1'b1;
                end
                else
                begin
                    pcount_reg <= pcount_reg + PCW'(1);
                end
            end
            if (op_txt)
            begin
                if (txt_full)
                begin
                    ovf_seen_reg <= 1'b1;
                end
                else
                begin
                    tcount_reg <= tcount_reg + TCW'(1);
                end
            end
            if (op_eval)
            begin
                pcount_reg   <= '0;
                tcount_reg   <= '0;
                ovf_seen_reg <= 1'b0;
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_eval)
        begin
            idx_reg       <= pcount_reg;
            row_reg       <= RW'(1) << tcount_reg;
            lane_mask_reg <= lane_mask_init;
            ovf_res_reg   <= ovf_seen_reg;
        end
        else if (state_reg == S_RUN && idx_reg != '0)
        begin
            idx_reg <= idx_reg - PCW'(1);
            row_reg <= row_next;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_beat_reg.matched  <= row_reg[0] & ~ovf_res_reg;
            out_beat_reg.overflow <= ovf_res_reg;
        end
    end

    a_busy_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> !in_ready)
        else $error("input accepted during evaluation");

    a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_beat_reg.overflow) |-> !out_beat_reg.matched)
        else $error("overflow result reports a match");

    a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
        op_eval |=> (pcount_reg == '0 && tcount_reg == '0 && !ovf_seen_reg))
        else $error("stores not cleared after evaluate");

    a_done_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && idx_reg == '0) |=> (state_reg == S_DONE))
        else $error("evaluation did not finish");

endmodule

// File: dv/wildcard_pattern_matcher_tb.sv
// Self-checking testbench for the wildcard pattern matcher: directed and random
// pattern/text loads with evaluate beats, checked against an in-bench matcher.
// Depends on wpm_pkg and the wildcard_pattern_matcher RTL.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_tb;
    import wpm_pkg::*;

    localparam int MAX_P = 64;
    localparam int MAX_T = 64;

    typedef struct {
        wpm_in_t beat;
        bit      drain_first;
    } send_item_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    wpm_in_t  in_beat = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    wpm_out_t out_beat;

    send_item_t beats_to_send[$];
    wpm_out_t   verdicts_due[$];
    int         results_owed;
    int         error_count;
    int         load_total;
    int         burst_left;
    int         gap_left;
    int         rx_cycle;
    int         case_index;

    logic [7:0] pat_mem [MAX_P];
    logic [7:0] txt_mem [MAX_T];
    int         pat_len;
    int         txt_len;
    bit         ovf_seen;

    wildcard_pattern_matcher #(
        .MAX_PATTERN(MAX_P),
        .MAX_TEXT   (MAX_T)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_beat  (in_beat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_beat (out_beat)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic predict_match();
        bit         row [MAX_T + 1];
        bit         diag;
        bit         prev;
        bit         lit;
        bit         any_one;
        logic [7:0] pc;
        for (int j = 0; j <= txt_len; j++)
        begin
            row[j] = 1'b0;
        end
        row[txt_len] = 1'b1;
        for (int i = pat_len; i > 0; i--)
        begin
            pc = pat_mem[i - 1];
            lit = (pc >= CH_LOW) && (pc <= CH_HIGH);
            any_one = (pc == CH_ANY);
            diag = row[txt_len];
            if (lit || any_one)
            begin
                row[txt_len] = 1'b0;
            end
            for (int j = txt_len; j > 0; j--)
            begin
                prev = row[j - 1];
                if (lit)
                begin
                    row[j - 1] = (txt_mem[j - 1] == pc) ? diag : 1'b0;
                end
                else if (any_one)
                begin
                    row[j - 1] = diag;
                end
                else
                begin
                    row[j - 1] = row[j - 1] | row[j];
                end
                diag = prev;
            end
        end
        return row[0];
    endfunction

    task automatic absorb_beat(input wpm_in_t b);
        wpm_out_t want;
        case (wpm_op_t'(b.opcode))
            OP_PATTERN:
            begin
                if (pat_len < MAX_P)
                begin
                    pat_mem[pat_len] = b.symbol;
                    pat_len++;
                end
                else
                begin
                    ovf_seen = 1'b1;
                end
            end
            OP_TEXT:
            begin
                if (txt_len < MAX_T)
                begin
                    txt_mem[txt_len] = b.symbol;
                    txt_len++;
                end
                else
                begin
                    ovf_seen = 1'b1;
                end
            end
            OP_EVAL:
            begin
                want.matched = ovf_seen ? 1'b0 : predict_match();
                want.overflow = ovf_seen;
                verdicts_due.push_back(want);
                pat_len = 0;
                txt_len = 0;
                ovf_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic push_beat(input wpm_op_t op, input logic [7:0] sym, input bit drain);
        send_item_t item;
        item.beat.opcode = op;
        item.beat.symbol = sym;
        item.drain_first = drain;
        beats_to_send.push_back(item);
        if (op != OP_NONE)
        begin
            load_total++;
        end
    endtask

    function automatic logic [7:0] star_byte();
        logic [7:0] b;
        if ($urandom_range(0, 2) == 0)
        begin
            return CH_STAR;
        end
        b = 8'($urandom_range(0, 255));
        while (((b >= CH_LOW) && (b <= CH_HIGH)) || (b == CH_ANY))
        begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] text_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (sel < 5)
        begin
            return 8'($urandom_range(CH_LOW, CH_LOW + 3));
        end
        return 8'($urandom_range(CH_LOW, CH_HIGH));
    endfunction

    task automatic make_case(input bit drain);
        logic [7:0] txt[$];
        logic [7:0] pat[$];
        logic [7:0] t;
        int         sel;
        int         pick;
        int         tlen;
        int         k;
        int         pi;
        int         ti;
        int         order;
        bit         first;
        bit         use_pat;
        sel = $urandom_range(0, 99);
        if (sel < 2)
        begin
            tlen = $urandom_range(MAX_T - 4, MAX_T + 4);
        end
        else if (sel < 5)
        begin
            tlen = 0;
        end
        else
        begin
            tlen = $urandom_range(1, 12);
        end
        for (k = 0; k < tlen; k++)
        begin
            txt.push_back(text_byte());
        end
        if (sel >= 5 && sel < 13)
        begin
            for (k = $urandom_range(0, 10); k > 0; k--)
            begin
                pick = $urandom_range(0, 2);
                pat.push_back(pick == 0 ? text_byte() : (pick == 1 ? CH_ANY : star_byte()));
            end
        end
        else
        begin
            k = 0;
            while (k < tlen)
            begin
                pick = $urandom_range(0, 99);
                t = txt[k];
                if (pick < 55)
                begin
                    pat.push_back((t >= CH_LOW && t <= CH_HIGH) ? t : CH_ANY);
                    k++;
                end
                else if (pick < 70)
                begin
                    pat.push_back(CH_ANY);
                    k++;
                end
                else if (pick < 85)
                begin
                    pat.push_back(star_byte());
                    k += $urandom_range(0, 3);
                end
                else if (pick < 92)
                begin
                    pat.push_back(8'($urandom_range(CH_LOW, CH_HIGH)));
                    k++;
                end
                else
                begin
                    pat.push_back(star_byte());
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                pat.push_back(star_byte());
            end
        end
        if (sel == 2)
        begin
            while (pat.size() <= MAX_P + $urandom_range(0, 3))
            begin
                pat.push_back(text_byte());
            end
        end
        else
        begin
            while (pat.size() > MAX_P)
            begin
                void'(pat.pop_back());
            end
        end
        order = $urandom_range(0, 2);
        first = drain;
        pi = 0;
        ti = 0;
        while (pi < pat.size() || ti < txt.size())
        begin
            if (order == 0)
            begin
                use_pat = (pi < pat.size());
            end
            else if (order == 1)
            begin
                use_pat = (ti >= txt.size());
            end
            else
            begin
                use_pat = (ti >= txt.size()) || ((pi < pat.size()) && $urandom_range(0, 1));
            end
            if ($urandom_range(0, 19) == 0)
            begin
                push_beat(OP_NONE, 8'($urandom_range(0, 255)), first);
                first = 1'b0;
            end
            if (use_pat)
            begin
                push_beat(OP_PATTERN, pat[pi], first);
                pi++;
            end
            else
            begin
                push_beat(OP_TEXT, txt[ti], first);
                ti++;
            end
            first = 1'b0;
        end
        if ($urandom_range(0, 39) != 0)
        begin
            push_beat(OP_EVAL, 8'($urandom_range(0, 255)), first);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit         fire;
        send_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_beat <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (!in_valid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (beats_to_send.size() == 0 ||
                         (beats_to_send[0].drain_first && (fire || results_owed != 0)))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = beats_to_send.pop_front();
                    in_valid <= 1'b1;
                    in_beat <= nxt.beat;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= 800 && rx_cycle < 1400)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 256) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wpm_out_t want;
        if (!rst_n)
        begin
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %b",
                             $time, out_beat);
                    error_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (out_beat.matched !== want.matched)
                    begin
                        $display("%0t: matched mismatch, expected %b, actual %b",
                                 $time, want.matched, out_beat.matched);
                        error_count++;
                    end
                    if (out_beat.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow mismatch, expected %b, actual %b",
                                 $time, want.overflow, out_beat.overflow);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                absorb_beat(in_beat);
            end
            results_owed <= verdicts_due.size();
        end
    end

    initial
    begin
        push_beat(OP_EVAL, 8'h00, 1'b0);
        push_beat(OP_PATTERN, CH_STAR, 1'b0);
        push_beat(OP_EVAL, 8'hFF, 1'b0);
        push_beat(OP_TEXT, 8'h00, 1'b0);
        push_beat(OP_EVAL, 8'h00, 1'b0);
        push_beat(OP_PATTERN, CH_LOW, 1'b0);
        push_beat(OP_TEXT, CH_LOW, 1'b0);
        push_beat(OP_EVAL, 8'hA5, 1'b0);
        push_beat(OP_PATTERN, CH_ANY, 1'b0);
        push_beat(OP_TEXT, 8'hFF, 1'b0);
        push_beat(OP_NONE, 8'hFF, 1'b0);
        push_beat(OP_EVAL, 8'h5A, 1'b0);
        push_beat(OP_PATTERN, CH_HIGH, 1'b0);
        push_beat(OP_TEXT, CH_HIGH - 8'd1, 1'b0);
        push_beat(OP_EVAL, 8'h00, 1'b0);
        push_beat(OP_PATTERN, 8'hFF, 1'b0);
        push_beat(OP_TEXT, 8'h71, 1'b0);
        push_beat(OP_TEXT, 8'h72, 1'b0);
        push_beat(OP_EVAL, 8'h00, 1'b0);
        push_beat(OP_PATTERN, CH_LOW, 1'b0);
        push_beat(OP_PATTERN, 8'h00, 1'b0);
        push_beat(OP_TEXT, CH_LOW, 1'b0);
        push_beat(OP_EVAL, 8'h00, 1'b0);
        case_index = 0;
        while (load_total < 1900)
        begin
            make_case((case_index % 12) == 11);
            case_index++;
        end
        push_beat(OP_EVAL, 8'h00, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (beats_to_send.size() != 0 || in_valid || results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected %b, actual none",
                     $time, verdicts_due.size(), verdicts_due[0]);
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("wildcard_pattern_matcher verification clean");
        end
        else
        begin
            $display("wildcard_pattern_matcher verification failed");
        end
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("wildcard_pattern_matcher verification failed");
        $finish;
    end

endmodule

// File: wildcard_pattern_matcher.f
hdl/wpm_pkg.sv
hdl/wpm_row_step.sv
hdl/wildcard_pattern_matcher.sv
dv/wildcard_pattern_matcher_tb.sv
